// File: src/mts_pkg.sv
// shared types, codes and constants for the min-tracking stack
package mts_pkg;

    // default sizes
    localparam int DEF_STACK_DEPTH = 256;
    localparam int DEF_VALUE_WIDTH = 32;

    // field widths on the ports
    localparam int DATA_W    = 32;
    localparam int OPCODE_W  = 2;
    localparam int DEPTH_W   = 9;
    localparam int STATUS_W  = 2;
    localparam int S_FIELD_W = OPCODE_W + DATA_W;
    localparam int S_TDATA_W = ((S_FIELD_W + 7) / 8) * 8;
    localparam int M_FIELD_W = DATA_W + DATA_W + DEPTH_W + 1 + STATUS_W;
    localparam int M_TDATA_W = ((M_FIELD_W + 7) / 8) * 8;

    // request operations
    typedef enum logic [OPCODE_W-1:0] {
        OP_PUSH = 2'd0,
        OP_POP  = 2'd1,
        OP_PEEK = 2'd2
    } opcode_t;

    // result status codes
    typedef enum logic [STATUS_W-1:0] {
        STAT_OK        = 2'd0,
        STAT_OVERFLOW  = 2'd1,
        STAT_UNDERFLOW = 2'd2
    } status_t;

    // controller states
    typedef enum logic [1:0] {
        S_IDLE,
        S_POP_WAIT,
        S_MIN_WAIT,
        S_DONE
    } state_t;

    // commands from controller to datapath
    typedef struct packed {
        logic    push;       // write value, update top and min
        logic    pop_issue;  // drop top, start reads of new top and min position
        logic    pop_top;    // take new top, start read of new min value
        logic    load_min;   // take new min value
        logic    set_status;
        status_t status;
        logic    out_load;   // capture result into output register
    } cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic full;
        logic empty;
        logic pop_min;       // last pop removed the current minimum
    } dp_stat_t;

endpackage

// File: src/mts_datapath.sv
// datapath of the min-tracking stack: value store, position store, counts and result register
module mts_datapath #(
    parameter int STACK_DEPTH = mts_pkg::DEF_STACK_DEPTH,
    parameter int VALUE_WIDTH = mts_pkg::DEF_VALUE_WIDTH
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  mts_pkg::cmd_t                       cmd,
    input  logic signed [mts_pkg::DATA_W-1:0]   push_value,
    output mts_pkg::dp_stat_t                   stat,
    output logic        [mts_pkg::M_TDATA_W-1:0] result
);

    localparam int ADDR_W  = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int COUNT_W = $clog2(STACK_DEPTH + 1);
    localparam int PAD_W   = mts_pkg::M_TDATA_W - mts_pkg::M_FIELD_W;

    // storage
    logic signed [VALUE_WIDTH-1:0] value_mem [STACK_DEPTH];
    logic        [ADDR_W-1:0]      pos_mem   [STACK_DEPTH];

    logic [COUNT_W-1:0] vcount_reg, vcount_next;
    logic [COUNT_W-1:0] mcount_reg, mcount_next;

    logic signed [VALUE_WIDTH-1:0] top_reg;
    logic signed [VALUE_WIDTH-1:0] min_reg;
    logic        [ADDR_W-1:0]      minpos_reg;
    logic                          pop_min_reg;
    mts_pkg::status_t              status_reg;
    logic signed [VALUE_WIDTH-1:0] rd_top_reg;
    logic        [ADDR_W-1:0]      rd_pos_reg;
    logic signed [VALUE_WIDTH-1:0] rd_min_reg;
    logic        [mts_pkg::M_TDATA_W-1:0] out_reg;

    logic signed [VALUE_WIDTH-1:0] push_v;
    logic                          new_min;
    logic        [COUNT_W-1:0]     vcm1, vcm2, mcm2;
    logic                          pop_hit;
    logic signed [mts_pkg::DATA_W-1:0] top_out, min_out;
    logic                          is_empty;

    // pushed value at store width, signed
    assign push_v  = VALUE_WIDTH'(push_value);
    assign new_min = (mcount_reg == '0) || (push_v < min_reg);

    // addresses below the counts
    assign vcm1    = vcount_reg - COUNT_W'(1);
    assign vcm2    = vcount_reg - COUNT_W'(2);
    assign mcm2    = mcount_reg - COUNT_W'(2);
    assign pop_hit = (mcount_reg != '0) && (minpos_reg == vcm1[ADDR_W-1:0]);

    // count updates
    always_comb begin
        vcount_next = vcount_reg;
        mcount_next = mcount_reg;
        if (cmd.push) begin
            vcount_next = vcount_reg + COUNT_W'(1);
            if (new_min) begin
                mcount_next = mcount_reg + COUNT_W'(1);
            end
        end else if (cmd.pop_issue) begin
            vcount_next = vcm1;
            if (pop_hit) begin
                mcount_next = mcount_reg - COUNT_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vcount_reg <= '0;
            mcount_reg <= '0;
        end else begin
            vcount_reg <= vcount_next;
            mcount_reg <= mcount_next;
        end
    end

    // stores and working registers
    always_ff @(posedge aclk) begin
        if (cmd.push) begin
            value_mem[vcount_reg[ADDR_W-1:0]] <= push_v;
            top_reg <= push_v;
            if (new_min) begin
                pos_mem[mcount_reg[ADDR_W-1:0]] <= vcount_reg[ADDR_W-1:0];
                minpos_reg <= vcount_reg[ADDR_W-1:0];
                min_reg    <= push_v;
            end
        end
        if (cmd.pop_issue) begin
            rd_top_reg  <= value_mem[vcm2[ADDR_W-1:0]];
            rd_pos_reg  <= pos_mem[mcm2[ADDR_W-1:0]];
            pop_min_reg <= pop_hit;
        end
        if (cmd.pop_top) begin
            top_reg <= rd_top_reg;
            if (pop_min_reg) begin
                minpos_reg <= rd_pos_reg;
                rd_min_reg <= value_mem[rd_pos_reg];
            end
        end
        if (cmd.load_min) begin
            min_reg <= rd_min_reg;
        end
        if (cmd.set_status) begin
            status_reg <= cmd.status;
        end
        if (cmd.out_load) begin
            out_reg <= {{PAD_W{1'b0}}, status_reg, is_empty,
                        mts_pkg::DEPTH_W'(vcount_reg), min_out, top_out};
        end
    end

    // result fields, zero when empty
    assign is_empty = (vcount_reg == '0);
    assign top_out  = is_empty ? '0 : mts_pkg::DATA_W'(top_reg);
    assign min_out  = is_empty ? '0 : mts_pkg::DATA_W'(min_reg);

    assign stat.full    = (vcount_reg == COUNT_W'(STACK_DEPTH));
    assign stat.empty   = is_empty;
    assign stat.pop_min = pop_min_reg;
    assign result       = out_reg;

endmodule

// File: src/mts_ctrl.sv
// controller of the min-tracking stack: sequences each request and the result handshake
module mts_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  mts_pkg::opcode_t     opcode,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    input  mts_pkg::dp_stat_t    stat,
    output mts_pkg::cmd_t        cmd
);

    mts_pkg::state_t state_reg, state_next;
    logic            m_tvalid_reg, m_tvalid_next;
    logic            out_free;

    assign out_free = !m_tvalid_reg || m_tready;

    // state and result valid registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= mts_pkg::S_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // next state and commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        cmd.status = mts_pkg::STAT_OK;
        s_tready   = 1'b0;
        case (state_reg)
            mts_pkg::S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.set_status = 1'b1;
                    state_next     = mts_pkg::S_DONE;
                    case (opcode)
                        mts_pkg::OP_PUSH: begin
                            if (stat.full) begin
                                cmd.status = mts_pkg::STAT_OVERFLOW;
                            end else begin
                                cmd.push = 1'b1;
                            end
                        end
                        mts_pkg::OP_POP: begin
                            if (stat.empty) begin
                                cmd.status = mts_pkg::STAT_UNDERFLOW;
                            end else begin
                                cmd.pop_issue = 1'b1;
                                state_next    = mts_pkg::S_POP_WAIT;
                            end
                        end
                        default: begin
                            cmd.status = mts_pkg::STAT_OK;
                        end
                    endcase
                end
            end
            mts_pkg::S_POP_WAIT: begin
                cmd.pop_top = 1'b1;
                state_next  = stat.pop_min ? mts_pkg::S_MIN_WAIT : mts_pkg::S_DONE;
            end
            mts_pkg::S_MIN_WAIT: begin
                cmd.load_min = 1'b1;
                state_next   = mts_pkg::S_DONE;
            end
            mts_pkg::S_DONE: begin
                if (out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = mts_pkg::S_IDLE;
                end
            end
            default: begin
                state_next = mts_pkg::S_IDLE;
            end
        endcase
    end

    // result valid holds until taken
    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (cmd.out_load) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    assign m_tvalid = m_tvalid_reg;

endmodule

// File: src/min_tracking_stack.sv
// top level of the min-tracking stack: stream ports, controller and datapath
//
//  channel  | direction | tdata fields (lowest bit up)
//  s_       | in        | opcode[1:0], push_value[33:2], zero pad[39:34]
//  m_       | out       | top_value[31:0], min_value[63:32], depth[72:64],
//           |           | is_empty[73], status[75:74], zero pad[79:76]
//
// a push, peek or refused request goes from the accept state S_IDLE to S_DONE, which
// loads the result register; a pop adds S_POP_WAIT, and S_MIN_WAIT if it removes the
// current minimum (registered reads of the next minimum position, then of its value).
// reset clears the counts; the stores need no clearing pass.
// a new request is taken while the previous result waits in the output register;
// the next result then holds in its last cycle until the waiting one is taken.
module min_tracking_stack #(
    parameter int STACK_DEPTH = mts_pkg::DEF_STACK_DEPTH,
    parameter int VALUE_WIDTH = mts_pkg::DEF_VALUE_WIDTH
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [mts_pkg::S_TDATA_W-1:0]    s_tdata,   // opcode, push_value
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // top_value, min_value, depth, is_empty, status
    output logic [mts_pkg::M_TDATA_W-1:0]    m_tdata
);

    mts_pkg::cmd_t     cmd;
    mts_pkg::dp_stat_t stat;
    mts_pkg::opcode_t  opcode;
    logic signed [mts_pkg::DATA_W-1:0] push_value;

    // unpack request fields
    assign opcode     = mts_pkg::opcode_t'(s_tdata[mts_pkg::OPCODE_W-1:0]);
    assign push_value = s_tdata[mts_pkg::S_FIELD_W-1:mts_pkg::OPCODE_W];

    mts_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .opcode   (opcode),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    mts_datapath #(
        .STACK_DEPTH (STACK_DEPTH),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_datapath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .push_value (push_value),
        .stat       (stat),
        .result     (m_tdata)
    );

endmodule
